>>> hw/rtl/mlfd_pkg.sv
// Package for the marker/length frame deframer.
// Holds the shared widths, phase and result-kind codes, and the config and result structs.
// No dependencies.
package mlfd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned LenW  = 15;
	localparam int unsigned KindW = 2;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 15;

	typedef enum logic [2:0] {
		PH_HUNT1    = 3'd0,
		PH_HUNT2    = 3'd1,
		PH_LEN_LO   = 3'd2,
		PH_LEN_HI   = 3'd3,
		PH_PAYLOAD  = 3'd4,
		PH_END1     = 3'd5,
		PH_END2_OK  = 3'd6,
		PH_END2_BAD = 3'd7
	} phase_t;

	typedef enum logic [KindW-1:0] {
		KIND_DATA    = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD_END = 2'd2,
		KIND_BAD_LEN = 2'd3
	} kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_START_FIRST  = 3'd0,
		REG_START_SECOND = 3'd1,
		REG_END_FIRST    = 3'd2,
		REG_END_SECOND   = 3'd3,
		REG_MAX_PAYLOAD  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [ByteW-1:0] start_first;
		logic [ByteW-1:0] start_second;
		logic [ByteW-1:0] end_first;
		logic [ByteW-1:0] end_second;
		logic [LenW-1:0]  max_payload;
	} cfg_t;

	typedef struct packed {
		kind_t            kind;
		logic [ByteW-1:0] payload_byte;
		logic [LenW-1:0]  frame_length;
		logic             last;
	} res_t;

endpackage

>>> hw/rtl/mlfd_cfg.sv
// Configuration register file of the deframer: marker bytes and maximum payload length.
// Depends on mlfd_pkg.
module mlfd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mlfd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [mlfd_pkg::CfgDataW-1:0] cfg_data,
	output mlfd_pkg::cfg_t                cfg
);
	import mlfd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_first  <= 8'hAA;
			cfg_q.start_second <= 8'h55;
			cfg_q.end_first    <= 8'h55;
			cfg_q.end_second   <= 8'hAA;
			cfg_q.max_payload  <= 15'd8192;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_START_FIRST:  cfg_q.start_first  <= cfg_data[ByteW-1:0];
				REG_START_SECOND: cfg_q.start_second <= cfg_data[ByteW-1:0];
				REG_END_FIRST:    cfg_q.end_first    <= cfg_data[ByteW-1:0];
				REG_END_SECOND:   cfg_q.end_second   <= cfg_data[ByteW-1:0];
				REG_MAX_PAYLOAD:  cfg_q.max_payload  <= cfg_data[LenW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/mlfd_parse.sv
// Frame parser state machine: consumes one byte per accepted item and forms at most one result.
// Depends on mlfd_pkg.
module mlfd_parse (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [mlfd_pkg::ByteW-1:0]  rx_byte,
	input  mlfd_pkg::cfg_t              cfg,
	output logic                        res_push,
	output mlfd_pkg::res_t              res
);
	import mlfd_pkg::*;

	phase_t              phase_q, phase_d;
	logic [LenW-1:0]     decl_len_q, decl_len_d;
	logic [LenW-1:0]     bytes_left_q, bytes_left_d;
	logic [LenW-1:0]     len_full;
	logic [LenW-1:0]     left_dec;
	logic                len_bad;

	// Full length once the high byte arrives; bit 15 of the declared length is rx_byte[7].
	assign len_full = {rx_byte[ByteW-2:0], decl_len_q[ByteW-1:0]};
	assign len_bad  = rx_byte[ByteW-1] || (len_full > cfg.max_payload);
	assign left_dec = bytes_left_q - LenW'(1);

	always_comb begin
		phase_d      = phase_q;
		decl_len_d   = decl_len_q;
		bytes_left_d = bytes_left_q;
		res_push     = 1'b0;
		res          = '{kind: KIND_DATA, payload_byte: '0, frame_length: '0, last: 1'b0};
		case (phase_q)
			PH_HUNT1: begin
				if (rx_byte == cfg.start_first) phase_d = PH_HUNT2;
			end
			PH_HUNT2: begin
				if (rx_byte == cfg.start_second)     phase_d = PH_LEN_LO;
				else if (rx_byte == cfg.start_first) phase_d = PH_HUNT2;
				else                                 phase_d = PH_HUNT1;
			end
			PH_LEN_LO: begin
				decl_len_d = {{(LenW-ByteW){1'b0}}, rx_byte};
				phase_d    = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				decl_len_d = len_full;
				if (len_bad) begin
					res_push = 1'b1;
					res.kind = KIND_BAD_LEN;
					res.last = 1'b1;
					phase_d  = PH_HUNT1;
				end else begin
					bytes_left_d = len_full;
					phase_d      = (len_full == '0) ? PH_END1 : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				res_push         = 1'b1;
				res.payload_byte = rx_byte;
				bytes_left_d     = left_dec;
				if (left_dec == '0) phase_d = PH_END1;
			end
			PH_END1: begin
				phase_d = (rx_byte == cfg.end_first) ? PH_END2_OK : PH_END2_BAD;
			end
			PH_END2_OK, PH_END2_BAD: begin
				res_push         = 1'b1;
				res.kind         = (phase_q == PH_END2_OK && rx_byte == cfg.end_second) ?
				                   KIND_GOOD : KIND_BAD_END;
				res.frame_length = decl_len_q;
				res.last         = 1'b1;
				phase_d          = PH_HUNT1;
			end
			default: phase_d = PH_HUNT1;
		endcase
		if (!take) res_push = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT1;
			decl_len_q   <= '0;
			bytes_left_q <= '0;
		end else if (take) begin
			phase_q      <= phase_d;
			decl_len_q   <= decl_len_d;
			bytes_left_q <= bytes_left_d;
		end
	end

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> bytes_left_q != '0)
		else $error("payload phase entered with no bytes left");

	a_last_on_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res.last == (res.kind != KIND_DATA)))
		else $error("last flag disagrees with result kind");

	a_verdict_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.last |=> phase_q == PH_HUNT1)
		else $error("parser did not resume hunting after a verdict");

endmodule

>>> hw/rtl/mlfd_obuf.sv
// Two-entry output buffer (result register plus skid register) for the deframer results.
// Depends on mlfd_pkg.
module mlfd_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mlfd_pkg::res_t push_res,
	output logic           can_take,
	output logic           out_valid,
	input  logic           out_ready,
	output mlfd_pkg::res_t out_res
);
	import mlfd_pkg::*;

	logic main_valid_q, skid_valid_q;
	res_t main_q, skid_q;
	logic pop;

	assign pop       = main_valid_q && out_ready;
	assign can_take  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) skid_valid_q <= 1'b0;
		end else if (push) begin
			if (main_valid_q && !pop) skid_valid_q <= 1'b1;
			else                      main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) main_q <= skid_q;
		end else if (push) begin
			if (main_valid_q && !pop) skid_q <= push_res;
			else                      main_q <= push_res;
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held while result register is empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("result pushed into a full output buffer");

endmodule

>>> hw/rtl/marker_length_frame_deframer_top.sv
// Marker/length frame deframer, top level.
// Throughput: one received byte per clock cycle, sustained, as long as results are taken.
// Each result is registered in the output buffer before it shows on res_valid.
// The two-entry output buffer (result register plus skid) sets the rate: rx_ready is low only
// while both entries hold results. Reset (arst_n low, asynchronous) restores default markers,
// a maximum payload of 8192, the hunting state, and an empty output buffer.
module marker_length_frame_deframer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// Received byte stream.
	input  logic                          rx_valid,
	output logic                          rx_ready,
	input  logic [mlfd_pkg::ByteW-1:0]    rx_byte,
	// Result stream.
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [mlfd_pkg::KindW-1:0]    kind,
	output logic [mlfd_pkg::ByteW-1:0]    payload_byte,
	output logic [mlfd_pkg::LenW-1:0]     frame_length,
	output logic                          last,
	// Configuration writes.
	input  logic                          cfg_we,
	input  logic [mlfd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [mlfd_pkg::CfgDataW-1:0] cfg_data
);
	import mlfd_pkg::*;

	cfg_t cfg;
	res_t parse_res;
	res_t out_res;
	logic parse_push;
	logic take;

	// A byte is taken whenever the output buffer has a free slot; every byte
	// produces at most one result, so a free slot always suffices.
	assign take = rx_valid && rx_ready;

	mlfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The parser state machine updates its phase, declared length and byte
	// counter on each taken byte and forms the result in the same cycle.
	mlfd_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.rx_byte  (rx_byte),
		.cfg      (cfg),
		.res_push (parse_push),
		.res      (parse_res)
	);

	// Results are registered here, so the output side never reaches back
	// combinationally into the input handshake.
	mlfd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (parse_push),
		.push_res  (parse_res),
		.can_take  (rx_ready),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.out_res   (out_res)
	);

	assign kind         = out_res.kind;
	assign payload_byte = out_res.payload_byte;
	assign frame_length = out_res.frame_length;
	assign last         = out_res.last;

endmodule

>>> test/tb_marker_length_frame_deframer_top.sv
// Testbench for marker_length_frame_deframer_top: a directed byte table, then random framed
// traffic under several marker and length settings, every result checked by a local model or the table row.
// Depends on mlfd_pkg and the deframer RTL only.
`timescale 1ns / 1ps

module tb_marker_length_frame_deframer_top;
	import mlfd_pkg::*;

	// Register indexes from REG_COUNT up to the top of cfg_index are unused by the block.
	localparam int unsigned REG_COUNT       = 5;
	localparam int unsigned RANDOM_PHASES   = 6;
	localparam int unsigned ITEMS_PER_PHASE = 325;
	localparam int unsigned LONG_HOLD       = 300;
	localparam int unsigned REPORT_LIMIT    = 10;
	// Settle time after the drain, so that any byte still in flight has passed through the block.
	localparam int unsigned SETTLE_CYCLES   = 4;
	// About 2000 items even under the heaviest stalls; this limit is far above what they need.
	localparam int unsigned CYCLE_LIMIT     = 200000;

	localparam cfg_t RESET_CFG = '{
		start_first:  8'hAA,
		start_second: 8'h55,
		end_first:    8'h55,
		end_second:   8'hAA,
		max_payload:  15'd8192
	};
	localparam res_t NO_EVENT = '0;

	// Where the expectation for a driven byte comes from: the local model, or the table row
	// itself (either no result at all, or the result typed into the row).
	typedef enum logic [1:0] {
		SRC_MODEL,
		SRC_NONE,
		SRC_TABLE
	} exp_src_t;

	typedef struct packed {
		logic [ByteW-1:0] rx;
		exp_src_t         src;
		res_t             want;
	} byte_row_t;

	logic                clk;
	logic                arst_n;
	logic                rx_valid;
	logic                rx_ready;
	logic [ByteW-1:0]    rx_byte;
	logic                res_valid;
	logic                res_ready;
	logic [KindW-1:0]    kind;
	logic [ByteW-1:0]    payload_byte;
	logic [LenW-1:0]     frame_length;
	logic                last;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// These travel with rx_byte so the monitor knows how to check the item it sees accepted.
	exp_src_t item_src;
	res_t     item_exp;

	// Local copy of the deframer: its configuration and its frame-tracking state.
	cfg_t             model_cfg;
	phase_t           model_phase;
	logic [15:0]      model_len;
	logic [LenW-1:0]  model_left;

	// Frame events (payload bytes and verdicts) predicted but not yet seen at the output.
	res_t frame_events_due[$];

	int unsigned mismatch_count = 0;
	int unsigned sent_count     = 0;
	int unsigned snd_idle_pct   = 0;
	int unsigned rcv_idle_pct   = 0;
	int unsigned hold_cycles    = 0;
	int unsigned cycle_count    = 0;

	marker_length_frame_deframer_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.frame_length (frame_length),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a run that has not finished by the limit has hung somewhere.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Builds a typed expectation for a table row. Every kind but a payload byte closes a frame.
	function automatic res_t event_of(input kind_t k, input logic [ByteW-1:0] pb,
			input logic [LenW-1:0] len);
		res_t r;
		r.kind         = k;
		r.payload_byte = pb;
		r.frame_length = len;
		r.last         = (k != KIND_DATA);
		return r;
	endfunction

	// Advances the local deframer by one received byte. Returns 1 when the byte yields a frame
	// event, which is then placed in ev.
	function automatic bit deframe_byte(input logic [ByteW-1:0] b, output res_t ev);
		bit made;
		made = 1'b0;
		ev   = NO_EVENT;
		case (model_phase)
			PH_HUNT1: begin
				if (b == model_cfg.start_first)
					model_phase = PH_HUNT2;
			end
			PH_HUNT2: begin
				// A failed second marker byte may itself be the first byte of a new marker.
				if (b == model_cfg.start_second)
					model_phase = PH_LEN_LO;
				else if (b == model_cfg.start_first)
					model_phase = PH_HUNT2;
				else
					model_phase = PH_HUNT1;
			end
			PH_LEN_LO: begin
				model_len   = {8'h00, b};
				model_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				model_len = {b, model_len[7:0]};
				if (model_len[15] || model_len[LenW-1:0] > model_cfg.max_payload) begin
					ev.kind     = KIND_BAD_LEN;
					ev.last     = 1'b1;
					made        = 1'b1;
					model_phase = PH_HUNT1;
				end else begin
					model_left  = model_len[LenW-1:0];
					model_phase = (model_left == '0) ? PH_END1 : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				ev.kind         = KIND_DATA;
				ev.payload_byte = b;
				made            = 1'b1;
				model_left      = model_left - 1'b1;
				if (model_left == '0)
					model_phase = PH_END1;
			end
			PH_END1: begin
				model_phase = (b == model_cfg.end_first) ? PH_END2_OK : PH_END2_BAD;
			end
			default: begin
				// Both end bytes are always taken; the verdict comes with the second one.
				if (model_phase == PH_END2_OK && b == model_cfg.end_second)
					ev.kind = KIND_GOOD;
				else
					ev.kind = KIND_BAD_END;
				ev.frame_length = model_len[LenW-1:0];
				ev.last         = 1'b1;
				made            = 1'b1;
				model_phase     = PH_HUNT1;
			end
		endcase
		return made;
	endfunction

	// Monitor. Signals are read right at the clock edge, before any of this edge's updates land,
	// so both sides see the same handshake. A result accepted at an edge can only stem from an
	// earlier byte, so the output is checked before this edge's byte is predicted.
	always @(posedge clk) begin
		res_t want;
		res_t seen;
		res_t ev;
		bit   made;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				seen.kind         = kind_t'(kind);
				seen.payload_byte = payload_byte;
				seen.frame_length = frame_length;
				seen.last         = last;
				if (frame_events_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected frame event: kind %0d byte %02h length %0d last %0b",
							seen.kind, seen.payload_byte, seen.frame_length, seen.last);
				end else begin
					want = frame_events_due.pop_front();
					if (want.kind !== seen.kind || want.payload_byte !== seen.payload_byte ||
							want.frame_length !== seen.frame_length || want.last !== seen.last) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$write("frame event differs: expected kind %0d byte %02h length %0d",
								want.kind, want.payload_byte, want.frame_length);
							$display(" last %0b, got kind %0d byte %02h length %0d last %0b",
								want.last, seen.kind, seen.payload_byte, seen.frame_length,
								seen.last);
						end
					end
				end
			end
			if (rx_valid && rx_ready) begin
				// The model always advances; a table row may override what it expects.
				made = deframe_byte(rx_byte, ev);
				case (item_src)
					SRC_MODEL: begin
						if (made)
							frame_events_due.push_back(ev);
					end
					SRC_TABLE: begin
						frame_events_due.push_back(item_exp);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result side: ready drops at random, or for a long counted stretch when hold_cycles is set.
	// During that stretch the two-entry output buffer fills and the block must stall rx_ready.
	initial begin
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				res_ready <= 1'b0;
				hold_cycles--;
			end else begin
				res_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
			end
		end
	end

	// Offers one byte, after a random gap, and holds it steady until it is taken.
	task automatic offer_byte(input logic [ByteW-1:0] b, input exp_src_t src, input res_t want);
		while ($urandom_range(99, 0) < snd_idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		item_src <= src;
		item_exp <= want;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
		sent_count++;
	endtask

	// Stops sending and waits until every predicted event has been taken, then lets a byte that
	// causes no result settle inside the block.
	task automatic drain_results();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (frame_events_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// One register write; the local configuration follows it at the same edge.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_START_FIRST:  model_cfg.start_first  = val[ByteW-1:0];
			REG_START_SECOND: model_cfg.start_second = val[ByteW-1:0];
			REG_END_FIRST:    model_cfg.end_first    = val[ByteW-1:0];
			REG_END_SECOND:   model_cfg.end_second   = val[ByteW-1:0];
			REG_MAX_PAYLOAD:  model_cfg.max_payload  = val[LenW-1:0];
			default: begin
			end
		endcase
	endtask

	// Writes all five registers, with junk in the unused upper data bits of the marker
	// registers, plus one write to an unused index that the block must ignore.
	task automatic program_setting(input logic [ByteW-1:0] sf, input logic [ByteW-1:0] ss,
			input logic [ByteW-1:0] ef, input logic [ByteW-1:0] es, input logic [LenW-1:0] mp);
		write_reg(REG_START_FIRST,  {7'($urandom), sf});
		write_reg(REG_START_SECOND, {7'($urandom), ss});
		write_reg(REG_END_FIRST,    {7'($urandom), ef});
		write_reg(REG_END_SECOND,   {7'($urandom), es});
		write_reg(REG_MAX_PAYLOAD,  mp);
		write_reg(CfgIdxW'($urandom_range(2 ** CfgIdxW - 1, REG_COUNT)), CfgDataW'($urandom));
		cfg_we <= 1'b0;
	endtask

	initial begin
		byte_row_t        rows[$];
		logic [15:0]      len;
		logic [ByteW-1:0] ef;
		logic [ByteW-1:0] es;
		int unsigned      target;
		int unsigned      pick;

		arst_n    = 1'b0;
		rx_valid  = 1'b0;
		rx_byte   = '0;
		item_src  = SRC_NONE;
		item_exp  = NO_EVENT;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		model_cfg   = RESET_CFG;
		model_phase = PH_HUNT1;
		model_len   = '0;
		model_left  = '0;

		snd_idle_pct = 15;
		rcv_idle_pct = 57;

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed part, under the reset markers (AA 55 ... 55 AA) and a maximum of 8192.
		// Noise at both byte extremes while hunting.
		rows.push_back('{8'h00, SRC_NONE, NO_EVENT});
		rows.push_back('{8'hFF, SRC_NONE, NO_EVENT});
		// Broken start marker: a repeated first byte keeps the hunt alive, then a stray byte
		// sends it back to the beginning.
		rows.push_back('{8'hAA, SRC_NONE, NO_EVENT});
		rows.push_back('{8'hAA, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h12, SRC_NONE, NO_EVENT});
		// Length with the sign bit set.
		rows.push_back('{8'hAA, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h55, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h00, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h80, SRC_TABLE, event_of(KIND_BAD_LEN, 8'h00, '0)});
		// Length one above the maximum.
		rows.push_back('{8'hAA, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h55, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h01, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h20, SRC_TABLE, event_of(KIND_BAD_LEN, 8'h00, '0)});
		// Zero length: the end marker follows the length at once.
		rows.push_back('{8'hAA, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h55, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h00, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h00, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h55, SRC_NONE, NO_EVENT});
		rows.push_back('{8'hAA, SRC_TABLE, event_of(KIND_GOOD, 8'h00, 15'd2 - 15'd2)});
		// Two payload bytes at the extremes, then a wrong second end byte.
		rows.push_back('{8'hAA, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h55, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h02, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h00, SRC_NONE, NO_EVENT});
		rows.push_back('{8'hFF, SRC_TABLE, event_of(KIND_DATA, 8'hFF, '0)});
		rows.push_back('{8'h00, SRC_TABLE, event_of(KIND_DATA, 8'h00, '0)});
		rows.push_back('{8'h55, SRC_NONE, NO_EVENT});
		rows.push_back('{8'h00, SRC_TABLE, event_of(KIND_BAD_END, 8'h00, 15'd2)});
		foreach (rows[i])
			offer_byte(rows[i].rx, rows[i].src, rows[i].want);
		drain_results();

		// Random part. Each phase runs under one setting; the setting changes only while the
		// block is drained, which can leave it in the middle of a frame, so a new setting
		// also gets applied to a frame already under way.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					// Reset setting; the receiver also takes one long break in this phase.
					hold_cycles = LONG_HOLD;
				end
				1: program_setting(8'h00, 8'hFF, 8'hFF, 8'h00, '0);
				2: program_setting(8'hFF, 8'hFF, 8'h00, 8'h00, '1);
				3: program_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					LenW'($urandom_range(20, 1)));
				4: program_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					LenW'($urandom));
				default: program_setting(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), LenW'($urandom_range(40, 1)));
			endcase

			// Sender idles lightly and receiver heavily, then the reverse, then neither.
			if (p < 2) begin
				snd_idle_pct = 15;
				rcv_idle_pct = 57;
			end else if (p < 4) begin
				snd_idle_pct = 57;
				rcv_idle_pct = 15;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end

			target = sent_count + ITEMS_PER_PHASE;
			while (sent_count < target) begin
				pick = $urandom_range(99, 0);
				if (pick < 70) begin
					// Frame, well-formed when its length is valid. Lengths are mostly short; the limit itself
					// is used only while it is small; the value just above it and lengths with bit 15 set also occur.
					pick = $urandom_range(99, 0);
					if (pick < 65 || (pick < 75 && model_cfg.max_payload > 48))
						len = 16'($urandom_range(12, 0));
					else if (pick < 75)
						len = {1'b0, model_cfg.max_payload};
					else if (pick < 85 && model_cfg.max_payload != '1)
						len = {1'b0, model_cfg.max_payload} + 16'd1;
					else
						len = {1'b1, LenW'($urandom)};
					offer_byte(model_cfg.start_first, SRC_MODEL, NO_EVENT);
					offer_byte(model_cfg.start_second, SRC_MODEL, NO_EVENT);
					offer_byte(len[7:0], SRC_MODEL, NO_EVENT);
					offer_byte(len[15:8], SRC_MODEL, NO_EVENT);
					if (!len[15] && len[LenW-1:0] <= model_cfg.max_payload) begin
						repeat (len)
							offer_byte(8'($urandom), SRC_MODEL, NO_EVENT);
						// Now and then spoil the first, the second or both end bytes.
						ef   = model_cfg.end_first;
						es   = model_cfg.end_second;
						pick = $urandom_range(99, 0);
						if (pick < 15)
							ef = ef ^ 8'($urandom_range(255, 1));
						if (pick >= 8 && pick < 22)
							es = es ^ 8'($urandom_range(255, 1));
						offer_byte(ef, SRC_MODEL, NO_EVENT);
						offer_byte(es, SRC_MODEL, NO_EVENT);
					end
				end else if (pick < 85) begin
					// Start marker broken after its first byte, possibly by a repeat of it.
					offer_byte(model_cfg.start_first, SRC_MODEL, NO_EVENT);
					offer_byte($urandom_range(1, 0) ? model_cfg.start_first : 8'($urandom),
						SRC_MODEL, NO_EVENT);
					offer_byte(8'($urandom), SRC_MODEL, NO_EVENT);
				end else begin
					repeat ($urandom_range(6, 1))
						offer_byte(8'($urandom), SRC_MODEL, NO_EVENT);
				end
			end
			drain_results();
		end

		if (mismatch_count == 0 && frame_events_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
